// File: rtl/glpf_pkg.sv
// Shared constants and types for the grid local peak finder.
package glpf_pkg;

  localparam int MAX_ROWS  = 32;
  localparam int MAX_COLS  = 32;
  localparam int CELL_W    = 32;
  localparam int DIM_W     = 6;
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = CFG_IDX_W'(1);

  typedef struct packed {
    logic first_col;
    logic last_col;
    logic has_up;
  } win_pos_t;

endpackage

// File: rtl/glpf_window.sv
// Line delays and neighbor compare for one decided cell per beat.
module glpf_window
  import glpf_pkg::*;
(
  input  logic                     clk,
  input  logic                     advance,
  input  logic signed [CELL_W-1:0] pixel,
  input  logic        [DIM_W-1:0]  cols,
  input  win_pos_t                 pos,
  output logic                     is_peak
);

  logic signed [CELL_W-1:0] line_a [MAX_COLS];
  logic signed [CELL_W-1:0] line_b [MAX_COLS];
  logic signed [CELL_W-1:0] center;
  logic signed [CELL_W-1:0] left_val;

  logic        [DIM_W-1:0]  tap_a_full;
  logic        [DIM_W-1:0]  tap_b_full;
  logic        [COL_W-1:0]  tap_a;
  logic        [COL_W-1:0]  tap_b;
  logic signed [CELL_W-1:0] right_tap;
  logic signed [CELL_W-1:0] up_n;
  logic signed [CELL_W-1:0] left_n;
  logic signed [CELL_W-1:0] right_n;

  assign tap_a_full = cols - DIM_W'(2);
  assign tap_b_full = cols - DIM_W'(1);
  assign tap_a      = tap_a_full[COL_W-1:0];
  assign tap_b      = tap_b_full[COL_W-1:0];

  assign right_tap = (cols == DIM_W'(1)) ? pixel : line_a[tap_a];
  assign up_n      = pos.has_up    ? line_b[tap_b] : '0;
  assign left_n    = pos.first_col ? '0 : left_val;
  assign right_n   = pos.last_col  ? '0 : right_tap;

  assign is_peak = (center >= up_n) && (center >= pixel) &&
                   (center >= left_n) && (center >= right_n);

  always_ff @(posedge clk) begin
    if (advance) begin
      line_a[0] <= pixel;
      line_b[0] <= center;
      for (int i = 1; i < MAX_COLS; i++) begin
        line_a[i] <= line_a[i-1];
        line_b[i] <= line_b[i-1];
      end
      center   <= right_tap;
      left_val <= center;
    end
  end

endmodule

// File: rtl/grid_local_peak_finder.sv
// Top level of the grid local peak finder: counters, config and result register.
//
// Cells arrive in raster order, one beat per clock, followed by one flush row of
// grid_cols beats whose values are ignored. Every beat from the second row on
// decides the cell one row above it and yields one result beat, in the cycle after
// acceptance, through a single result register; the input is taken in every
// cycle unless a result waits and the output stalls. Neighbors are held in two
// shift lines of MAX_COLS entries whose tap follows grid_cols, so no clearing
// pass follows reset. A register write restarts the frame.
module grid_local_peak_finder
  import glpf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DIM_W-1:0]         cfg_data,
  input  logic                     cell_valid,
  output logic                     cell_stall,
  input  logic signed [CELL_W-1:0] cell_value,
  output logic                     peak_valid,
  input  logic                     peak_stall,
  output logic                     is_peak,
  output logic [ROW_W-1:0]         peak_row,
  output logic [COL_W-1:0]         peak_col,
  output logic                     frame_end
);

  logic [DIM_W-1:0] rows_reg;
  logic [DIM_W-1:0] cols_reg;
  logic [DIM_W-1:0] row_count;
  logic [COL_W-1:0] col_count;

  logic [DIM_W-1:0]         cfg_clamped;
  logic                     accept;
  logic                     flush_row;
  logic                     last_col;
  logic [DIM_W-1:0]         col_plus;
  logic [DIM_W-1:0]         row_minus;
  logic signed [CELL_W-1:0] pixel;
  logic                     win_peak;
  win_pos_t                 pos;

  always_comb begin
    if (cfg_data == '0) begin
      cfg_clamped = DIM_W'(1);
    end else if (cfg_data > DIM_W'(MAX_ROWS)) begin
      cfg_clamped = DIM_W'(MAX_ROWS);
    end else begin
      cfg_clamped = cfg_data;
    end
  end

  assign cell_stall = peak_valid && peak_stall;
  assign accept     = cell_valid && !cell_stall;
  assign flush_row  = (row_count == rows_reg);
  assign col_plus   = {1'b0, col_count} + DIM_W'(1);
  assign last_col   = (col_plus == cols_reg);
  assign row_minus  = row_count - DIM_W'(1);
  assign pixel      = flush_row ? '0 : cell_value;

  assign pos.first_col = (col_count == '0);
  assign pos.last_col  = last_col;
  assign pos.has_up    = (row_count >= DIM_W'(2));

  glpf_window u_window (
    .clk     (clk),
    .advance (accept),
    .pixel   (pixel),
    .cols    (cols_reg),
    .pos     (pos),
    .is_peak (win_peak)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_reg   <= DIM_W'(MAX_ROWS);
      cols_reg   <= DIM_W'(MAX_COLS);
      row_count  <= '0;
      col_count  <= '0;
      peak_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GRID_ROWS: rows_reg <= cfg_clamped;
          REG_GRID_COLS: cols_reg <= (cfg_clamped > DIM_W'(MAX_COLS)) ?
                                     DIM_W'(MAX_COLS) : cfg_clamped;
          default: ;
        endcase
        row_count <= '0;
        col_count <= '0;
      end else if (accept) begin
        if (last_col) begin
          col_count <= '0;
          row_count <= flush_row ? '0 : row_count + DIM_W'(1);
        end else begin
          col_count <= col_plus[COL_W-1:0];
        end
      end
      if (accept && row_count != '0) begin
        peak_valid <= 1'b1;
      end else if (!peak_stall) begin
        peak_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && row_count != '0) begin
      is_peak   <= win_peak;
      peak_row  <= row_minus[ROW_W-1:0];
      peak_col  <= col_count;
      frame_end <= flush_row && last_col;
    end
  end

`ifndef SYNTH
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, col_count} < cols_reg)
    else $error("column counter beyond grid_cols");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    row_count <= rows_reg)
    else $error("row counter beyond flush row");

  a_frame_end_col: assert property (@(posedge clk) disable iff (rst)
    peak_valid && frame_end |-> {1'b0, peak_col} == cols_reg - DIM_W'(1))
    else $error("frame end flagged away from last column");

  a_first_row_silent: assert property (@(posedge clk) disable iff (rst)
    accept && row_count == '0 && !peak_stall |=> !peak_valid)
    else $error("first row beat produced a result");
`endif

endmodule

// File: tb/tb_grid_local_peak_finder.sv
// Self-checking testbench for grid_local_peak_finder: raster frames under random stalls.
module tb_grid_local_peak_finder;
  import glpf_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    logic             is_peak;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             frame_end;
  } peak_t;

  class peak_scoreboard;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;
    logic signed [CELL_W-1:0] upper_row [MAX_COLS];
    logic signed [CELL_W-1:0] middle_row [MAX_COLS];
    int unsigned row_at;
    int unsigned col_at;
    peak_t pending_peaks[$];
    int unsigned mismatches;

    function new();
      rows_reg = DIM_W'(MAX_ROWS);
      cols_reg = DIM_W'(MAX_COLS);
      row_at = 0;
      col_at = 0;
      mismatches = 0;
    endfunction

    function int unsigned span(logic [DIM_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int unsigned frame_cells();
      return (span(rows_reg, MAX_ROWS) + 1) * span(cols_reg, MAX_COLS);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] d);
      if (idx == REG_GRID_ROWS) rows_reg = d;
      else cols_reg = d;
      row_at = 0;
      col_at = 0;
    endfunction

    function void take_cell(logic signed [CELL_W-1:0] v);
      int unsigned nr, nc, r, c;
      logic signed [CELL_W-1:0] val, center, up, left, right;
      peak_t p;
      nr = span(rows_reg, MAX_ROWS);
      nc = span(cols_reg, MAX_COLS);
      if (col_at >= nc) col_at = 0;
      if (row_at > nr) row_at = 0;
      r = row_at;
      c = col_at;
      val = (r == nr) ? '0 : v;
      if (r >= 1) begin
        center = middle_row[c];
        up = (r >= 2) ? upper_row[c] : '0;
        left = (c >= 1) ? upper_row[c-1] : '0;
        right = (c + 1 < nc) ? middle_row[c+1] : '0;
        p.is_peak = center >= up && center >= val && center >= left && center >= right;
        p.row = ROW_W'(r - 1);
        p.col = COL_W'(c);
        p.frame_end = (r == nr) && (c + 1 == nc);
        pending_peaks.push_back(p);
      end
      upper_row[c] = middle_row[c];
      middle_row[c] = val;
      if (c + 1 >= nc) begin
        col_at = 0;
        row_at = (r >= nr) ? 0 : r + 1;
      end else begin
        col_at = c + 1;
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_peak(logic pk, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                             logic fe);
      peak_t want;
      if (pending_peaks.size() == 0) begin
        $error("unexpected result beat: row %0d col %0d", row, col);
        mismatches++;
        return;
      end
      want = pending_peaks.pop_front();
      compare_field("is_peak", 8'(want.is_peak), 8'(pk));
      compare_field("peak_row", 8'(want.row), 8'(row));
      compare_field("peak_col", 8'(want.col), 8'(col));
      compare_field("frame_end", 8'(want.frame_end), 8'(fe));
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_write;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [DIM_W-1:0]         cfg_data;
  logic                     cell_valid;
  logic                     cell_stall;
  logic signed [CELL_W-1:0] cell_value;
  logic                     peak_valid;
  logic                     peak_stall;
  logic                     is_peak;
  logic [ROW_W-1:0]         peak_row;
  logic [COL_W-1:0]         peak_col;
  logic                     frame_end;

  peak_scoreboard board = new();
  int unsigned cells_accepted = 0;

  grid_local_peak_finder dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cell_valid(cell_valid),
    .cell_stall(cell_stall),
    .cell_value(cell_value),
    .peak_valid(peak_valid),
    .peak_stall(peak_stall),
    .is_peak(is_peak),
    .peak_row(peak_row),
    .peak_col(peak_col),
    .frame_end(frame_end)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit steady();
    return cells_accepted >= 900 && cells_accepted < 1300;
  endfunction

  function automatic logic signed [CELL_W-1:0] rand_cell();
    case ($urandom_range(15))
      0, 1: return $urandom;
      2: return 32'sh7FFFFFFF;
      3: return 32'sh80000000;
      default: return CELL_W'($urandom_range(0, 6)) - 3;
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(15))
      0: return '0;
      1: return 6'd63;
      2: return 6'd32;
      3: return DIM_W'($urandom_range(33, 62));
      4: return 6'd1;
      default: return DIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic send_cell(input logic signed [CELL_W-1:0] v);
    while (!steady() && $urandom_range(99) < 6) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid <= 1'b1;
    cell_value <= v;
    do @(posedge clk); while (cell_stall);
    board.take_cell(v);
    cells_accepted++;
  endtask

  task automatic send_cells(input int unsigned n);
    repeat (n) send_cell(rand_cell());
  endtask

  task automatic settle();
    cell_valid <= 1'b0;
    while (board.pending_peaks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    board.set_reg(idx, d);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    logic signed [CELL_W-1:0] pattern [6];
    logic [DIM_W-1:0] n_rows, n_cols;
    int unsigned frames, cells_per_frame;
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_GRID_ROWS;
    cfg_data <= '0;
    cell_valid <= 1'b0;
    cell_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_cell(32'sh7FFFFFFF);
    send_cell(32'sh80000000);
    send_cell('0);
    settle();
    write_reg(REG_GRID_ROWS, '0);
    write_reg(REG_GRID_COLS, '0);
    send_cell(32'sh7FFFFFFF);
    send_cell(rand_cell());
    send_cell(32'sh80000000);
    send_cell(rand_cell());
    settle();
    write_reg(REG_GRID_ROWS, 6'd2);
    write_reg(REG_GRID_COLS, 6'd3);
    pattern = '{-32'sd1, 32'sh7FFFFFFF, 32'sd5, 32'sd5, 32'sd5, 32'sh80000000};
    foreach (pattern[i]) send_cell(pattern[i]);
    send_cells(3);
    settle();
    write_reg(REG_GRID_ROWS, 6'd1);
    write_reg(REG_GRID_COLS, 6'd2);
    send_cell(32'sd3);
    send_cell(32'sd3);
    send_cells(2);

    while (cells_accepted < 1900) begin
      settle();
      n_rows = pick_dim();
      n_cols = pick_dim();
      if (board.span(n_rows, MAX_ROWS) * board.span(n_cols, MAX_COLS) > 96) begin
        if ($urandom_range(1)) n_rows = DIM_W'($urandom_range(1, 3));
        else n_cols = DIM_W'($urandom_range(1, 3));
      end
      write_reg(REG_GRID_ROWS, n_rows);
      write_reg(REG_GRID_COLS, n_cols);
      cells_per_frame = board.frame_cells();
      frames = $urandom_range(1, 3);
      repeat (frames) send_cells(cells_per_frame);
      if ($urandom_range(5) == 0) send_cells($urandom_range(1, cells_per_frame - 1));
    end
    settle();

    if (board.mismatches == 0 && board.pending_peaks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    peak_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && peak_valid && !peak_stall) begin
        board.check_peak(is_peak, peak_row, peak_col, frame_end);
      end
      if (hold_left != 0) begin
        hold_left--;
        peak_stall <= 1'b1;
      end else if (!hold_done && cells_accepted >= 300 && cell_valid) begin
        hold_done = 1'b1;
        hold_left = 99;
        peak_stall <= 1'b1;
      end else begin
        peak_stall <= !steady() && $urandom_range(99) < 6;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (cell_valid && !cell_stall) || (peak_valid && !peak_stall)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

// File: files.f
rtl/glpf_pkg.sv
rtl/glpf_window.sv
rtl/grid_local_peak_finder.sv
tb/tb_grid_local_peak_finder.sv
